>>> hw/rtl/min_max_sample_normalizer_unit_assert.svh
// Assertion macros used by the normalizer checker file.
// No dependencies; included by bare file name.
`ifndef MIN_MAX_SAMPLE_NORMALIZER_UNIT_ASSERT_SVH
`define MIN_MAX_SAMPLE_NORMALIZER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define MMSN_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MMSN_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/mmsn_pkg.sv
// Shared types and constants of the min-max sample normalizer.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package mmsn_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned DivSteps = 16;

  localparam logic [SampleW-1:0] MinReset = 16'hFFFF;
  localparam logic [SampleW-1:0] MaxReset = 16'h0000;

  typedef enum logic {
    OP_MEASURE   = 1'b0,
    OP_NORMALIZE = 1'b1
  } opcode_e;

  typedef enum logic {
    MODE_8BIT  = 1'b0,
    MODE_16BIT = 1'b1
  } sample_mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  // One normalize job handed from the front to the divider back end.
  typedef struct packed {
    logic [SampleW-1:0] off;
    logic [SampleW-1:0] span;
    sample_mode_e       mode;
    logic               flat;
    logic               last;
  } norm_job_t;

endpackage

>>> hw/rtl/mmsn_front.sv
// Front end: accepts samples, tracks running min/max, builds normalize jobs.
// Depends on mmsn_pkg.
`timescale 1ns / 1ps

module mmsn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mmsn_pkg::sample_mode_e        mode_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mmsn_pkg::opcode_e             in_opcode_i,
  input  logic [mmsn_pkg::SampleW-1:0]  in_sample_i,
  input  logic                          in_last_i,
  input  logic                          q_full_i,
  output logic                          job_push_o,
  output mmsn_pkg::norm_job_t           job_o
);

  logic [mmsn_pkg::SampleW-1:0] min_q, min_d;
  logic [mmsn_pkg::SampleW-1:0] max_q, max_d;
  logic [mmsn_pkg::SampleW-1:0] sample_m;
  logic [mmsn_pkg::SampleW-1:0] sample_c;
  logic                         accept;
  logic                         flat;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Mask the sample to the active width
  always_comb begin
    if (mode_i == mmsn_pkg::MODE_8BIT) begin
      sample_m = {8'h00, in_sample_i[7:0]};
    end else begin
      sample_m = in_sample_i;
    end
  end

  // Clamp into the measured range and form the job
  always_comb begin
    flat = (max_q <= min_q);
    sample_c = sample_m;
    if (sample_c < min_q) begin
      sample_c = min_q;
    end
    if (sample_c > max_q) begin
      sample_c = max_q;
    end
    job_o.off  = sample_c - min_q;
    job_o.span = max_q - min_q;
    job_o.mode = mode_i;
    job_o.flat = flat;
    job_o.last = in_last_i;
    job_push_o = accept && (in_opcode_i == mmsn_pkg::OP_NORMALIZE);
  end

  // Fold measure samples into the bounds; clear them after the last normalize
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (accept) begin
      if (in_opcode_i == mmsn_pkg::OP_MEASURE) begin
        if (sample_m < min_q) begin
          min_d = sample_m;
        end
        if (sample_m > max_q) begin
          max_d = sample_m;
        end
      end else if (in_last_i) begin
        min_d = mmsn_pkg::MinReset;
        max_d = mmsn_pkg::MaxReset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= mmsn_pkg::MinReset;
      max_q <= mmsn_pkg::MaxReset;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

>>> hw/rtl/mmsn_queue.sv
// Small job queue between the front end and the divider back end.
// Depends on mmsn_pkg.
`timescale 1ns / 1ps

module mmsn_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mmsn_pkg::norm_job_t  push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output mmsn_pkg::norm_job_t  head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mmsn_pkg::norm_job_t entries_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/mmsn_div_back.sv
// Back end: scales the offset by full range and divides by the span,
// one restoring quotient bit per cycle, then holds the result. Depends on mmsn_pkg.
`timescale 1ns / 1ps

module mmsn_div_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  mmsn_pkg::norm_job_t           job_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mmsn_pkg::SampleW-1:0]  out_normalized_o,
  output logic                          out_flat_o,
  output logic                          out_last_o
);

  localparam int unsigned W    = mmsn_pkg::SampleW;
  localparam int unsigned CntW = $clog2(mmsn_pkg::DivSteps);

  mmsn_pkg::back_state_e state_q, state_d;

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    lo_q, lo_d;
  logic [W-1:0]    quot_q, quot_d;
  logic [W-1:0]    span_q, span_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            flat_q, flat_d;
  logic            last_q, last_d;

  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_data_q;
  logic            out_flat_q;
  logic            out_last_q;

  logic [2*W-1:0]  numer;
  logic [W:0]      trial;
  logic            fits;
  logic            emit_fire;
  logic            div_step;
  logic            div_done;

  // Numerator off * full as a shift and subtract
  always_comb begin
    if (job_i.mode == mmsn_pkg::MODE_16BIT) begin
      numer = {job_i.off, {W{1'b0}}} - {{W{1'b0}}, job_i.off};
    end else begin
      numer = {8'h00, job_i.off, 8'h00} - {{W{1'b0}}, job_i.off};
    end
  end

  // One restoring step
  assign trial    = {rem_q, lo_q[W-1]};
  assign fits     = (trial >= {1'b0, span_q});
  assign div_done = (cnt_q == CntW'(mmsn_pkg::DivSteps - 1));

  // Control outputs per state
  always_comb begin
    job_pop_o = 1'b0;
    div_step  = 1'b0;
    emit_fire = 1'b0;
    case (state_q)
      mmsn_pkg::BK_IDLE: job_pop_o = job_valid_i;
      mmsn_pkg::BK_DIV:  div_step  = 1'b1;
      mmsn_pkg::BK_EMIT: emit_fire = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmsn_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.flat ? mmsn_pkg::BK_EMIT : mmsn_pkg::BK_DIV;
        end
      end
      mmsn_pkg::BK_DIV: begin
        if (div_done) begin
          state_d = mmsn_pkg::BK_EMIT;
        end
      end
      mmsn_pkg::BK_EMIT: begin
        if (emit_fire) begin
          state_d = mmsn_pkg::BK_IDLE;
        end
      end
      default: state_d = mmsn_pkg::BK_IDLE;
    endcase
  end

  // Load a job or advance the divider datapath
  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    span_d = span_q;
    cnt_d  = cnt_q;
    flat_d = flat_q;
    last_d = last_q;
    if (job_pop_o) begin
      rem_d  = numer[2*W-1:W];
      lo_d   = numer[W-1:0];
      quot_d = '0;
      span_d = job_i.span;
      cnt_d  = '0;
      flat_d = job_i.flat;
      last_d = job_i.last;
    end else if (div_step) begin
      rem_d  = fits ? W'(trial - {1'b0, span_q}) : trial[W-1:0];
      lo_d   = {lo_q[W-2:0], 1'b0};
      quot_d = {quot_q[W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
    end
  end

  // Output register valid: set on emit, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmsn_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
    span_q <= span_d;
    cnt_q  <= cnt_d;
    flat_q <= flat_d;
    last_q <= last_d;
    if (emit_fire) begin
      out_data_q <= flat_q ? '0 : quot_q;
      out_flat_q <= flat_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_normalized_o = out_data_q;
  assign out_flat_o       = out_flat_q;
  assign out_last_o       = out_last_q;

endmodule

>>> hw/rtl/min_max_sample_normalizer_unit.sv
// Top level of the min-max sample normalizer (contrast stretch).
// Depends on mmsn_pkg, mmsn_front, mmsn_queue and mmsn_div_back.
//
// Channel   Dir  tdata (low bit up)      tuser          tlast
// s_axis    in   sample[15:0]            opcode         last_of_pass
// m_axis    out  normalized[15:0]        flat_range     last_out
// cfg       in   cfg_wdata_i: sample_mode, written when cfg_we_i is high
//
// A measure item is handled in the front end alone and gives no result.
// In the back end a normalize item is loaded from the queue, run through the
// radix-2 restoring divider and then emitted; a flat-range item skips the divider.
// The job queue (FIFO_DEPTH entries) lets the front keep taking items while
// the divider works; s_axis_tready drops only when the queue is full.
// Reset is asynchronous, active low: bounds return to min 65535, max 0, mode 8-bit.
`timescale 1ns / 1ps

module min_max_sample_normalizer_unit #(
  parameter int unsigned FIFO_DEPTH = 4  // job queue entries, 2..16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // [0] sample_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] opcode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] normalized
  output logic        m_axis_tuser,   // [0] flat_range
  output logic        m_axis_tlast
);

  mmsn_pkg::sample_mode_e mode_q, mode_d;
  mmsn_pkg::norm_job_t    push_job;
  mmsn_pkg::norm_job_t    head_job;
  logic                   job_push;
  logic                   job_pop;
  logic                   q_full;
  logic                   q_valid;

  // Hold the sample mode register
  always_comb begin
    mode_d = mode_q;
    if (cfg_we_i) begin
      mode_d = mmsn_pkg::sample_mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mmsn_pkg::MODE_8BIT;
    end else begin
      mode_q <= mode_d;
    end
  end

  mmsn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (mmsn_pkg::opcode_e'(s_axis_tuser)),
    .in_sample_i (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .job_push_o  (job_push),
    .job_o       (push_job)
  );

  mmsn_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (job_pop),
    .valid_o     (q_valid),
    .head_o      (head_job)
  );

  mmsn_div_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_valid),
    .job_i            (head_job),
    .job_pop_o        (job_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_normalized_o (m_axis_tdata),
    .out_flat_o       (m_axis_tuser),
    .out_last_o       (m_axis_tlast)
  );

endmodule

>>> hw/rtl/mmsn_checker.sv
// Port-level checks for the min-max sample normalizer, bound to the top level.
// Depends on min_max_sample_normalizer_unit_assert.svh.
`timescale 1ns / 1ps
`include "min_max_sample_normalizer_unit_assert.svh"

module mmsn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled result unchanged
  `MMSN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // A flat range always yields zero
  `MMSN_ASSERT_NOW(a_flat_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'h0000, "flat range with nonzero value")

  // No result can appear right after reset release
  `MMSN_ASSERT_NOW(a_reset_quiet, clk_i, rst_ni, $past(!rst_ni), !m_axis_tvalid, "result right after reset")

  // Keep the input ready known while a transfer is offered
  `MMSN_ASSERT_NOW(a_tready_known, clk_i, rst_ni, s_axis_tvalid, !$isunknown(s_axis_tready), "input ready unknown")

  // Drive known result fields whenever a result is offered
  `MMSN_ASSERT_NOW(a_out_known, clk_i, rst_ni, m_axis_tvalid, !$isunknown({m_axis_tdata, m_axis_tuser, m_axis_tlast}), "result fields unknown")

endmodule

bind min_max_sample_normalizer_unit mmsn_checker u_mmsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
